// ===== design/banp_pkg.sv =====
// shared types, constants and helpers for the box-average nearest-palette block
// no dependencies; imported by every module of the block
package banp_pkg;

  localparam int unsigned PAL_DEPTH = 256;
  localparam int unsigned PIX_COUNT = 9;
  localparam logic        OP_WRITE  = 1'b0;
  localparam logic        OP_BLOCK  = 1'b1;
  // floor(s / 9) for s <= 2295 as (s * 7282) >> 16
  localparam logic [12:0] RECIP9    = 13'd7282;

  typedef logic [7:0]  idx_t;
  typedef logic [23:0] rgb_t;
  typedef logic [11:0] sum_t;
  typedef logic [17:0] dist_t;

  typedef struct packed {
    logic op;
    idx_t entry_index;
    rgb_t entry_rgb;
    idx_t pix_00;
    idx_t pix_01;
    idx_t pix_02;
    idx_t pix_10;
    idx_t pix_11;
    idx_t pix_12;
    idx_t pix_20;
    idx_t pix_21;
    idx_t pix_22;
  } in_word_t;

  typedef struct packed {
    idx_t  nearest_index;
    dist_t best_distance;
  } out_word_t;

  // tag that travels with a search read
  typedef struct packed {
    logic v;
    idx_t idx;
    logic last;
  } srch_tag_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOKUP,
    S_LKEND,
    S_AVG,
    S_SEARCH,
    S_DRAIN,
    S_OUT
  } state_t;

  function automatic logic [7:0] div9(input sum_t s);
    logic [24:0] p;
    p = 25'(s) * 25'(RECIP9);
    return p[23:16];
  endfunction

endpackage

// ===== design/banp_pal_mem.sv =====
// palette memory: 256 x 24, one write port, one read port with registered data
// depends on banp_pkg
module banp_pal_mem (
  input  logic          clk,
  input  logic          we,
  input  banp_pkg::idx_t waddr,
  input  banp_pkg::rgb_t wdata,
  input  banp_pkg::idx_t raddr,
  output banp_pkg::rgb_t rdata
);
  import banp_pkg::*;

  rgb_t mem [PAL_DEPTH];
  rgb_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== design/banp_dist.sv =====
// squared rgb distance stage: one palette entry against the average, registered
// depends on banp_pkg
module banp_dist (
  input  logic               clk,
  input  logic               rst_n,
  input  banp_pkg::rgb_t     rgb,
  input  banp_pkg::rgb_t     avg,
  input  banp_pkg::srch_tag_t tag_in,
  output banp_pkg::dist_t    sq_dist,
  output banp_pkg::srch_tag_t tag_out
);
  import banp_pkg::*;

  logic [7:0]  dr, dg, db;
  logic [15:0] qr, qg, qb;
  dist_t       dist_nxt;
  dist_t       dist_r;
  srch_tag_t   tag_r;

  always_comb begin
    dr = (rgb[23:16] > avg[23:16]) ? rgb[23:16] - avg[23:16] : avg[23:16] - rgb[23:16];
    dg = (rgb[15:8] > avg[15:8]) ? rgb[15:8] - avg[15:8] : avg[15:8] - rgb[15:8];
    db = (rgb[7:0] > avg[7:0]) ? rgb[7:0] - avg[7:0] : avg[7:0] - rgb[7:0];
    qr = 16'(dr) * 16'(dr);
    qg = 16'(dg) * 16'(dg);
    qb = 16'(db) * 16'(db);
    dist_nxt = 18'(qr) + 18'(qg) + 18'(qb);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r <= '0;
    end else begin
      tag_r <= tag_in;
    end
    dist_r <= dist_nxt;
  end

  assign sq_dist = dist_r;
  assign tag_out = tag_r;

endmodule

// ===== design/box_average_nearest_palette.sv =====
// Box-average nearest-palette quantizer.
// Input channel (in_valid / in_stall / in_word): op 0 writes entry_rgb into
// palette entry entry_index and gives no result; op 1 averages the colors of
// the nine pix_* entries (floor of each channel sum over 9) and searches
// entries 0 .. SEARCH_ENTRIES-1 for the smallest squared distance, lowest
// index winning a tie.
// Output channel (out_valid / out_stall / out_word): one word per block item,
// nearest_index and best_distance.
// A block item makes nine lookups and then one search read per cycle
// through the single read port of the palette memory, followed by the
// memory and distance stages.
// in_stall is high while a block item is in work; write items are taken
// while a finished word still waits at the output.
// If out_stall holds the output word, a finished block item waits until the
// output register is free.
// Reset clears control state only; the palette is undefined until written
// and no clearing pass is made.
module box_average_nearest_palette #(
  parameter int unsigned SEARCH_ENTRIES = 224
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  banp_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output banp_pkg::out_word_t out_word
);
  import banp_pkg::*;

  localparam idx_t LAST_IDX = idx_t'(SEARCH_ENTRIES - 1);

  state_t    state_r, state_nxt;
  logic      in_acc;
  idx_t      pix_r [PIX_COUNT];
  logic [3:0] lk_cnt_r, lk_cnt_nxt;
  idx_t      sr_cnt_r, sr_cnt_nxt;
  logic      lk_v_r;
  sum_t      sum_r_r, sum_g_r, sum_b_r;
  rgb_t      avg_r;
  idx_t      raddr;
  rgb_t      rdata;
  srch_tag_t s1_tag_r, s2_tag;
  dist_t     s2_dist;
  idx_t      best_idx_r, best_idx_nxt;
  dist_t     best_dist_r, best_dist_nxt;
  logic      found_r, found_nxt;
  logic      out_valid_r;
  out_word_t out_word_r;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);

  banp_pal_mem u_mem (
    .clk   (clk),
    .we    (in_acc && (in_word.op == OP_WRITE)),
    .waddr (in_word.entry_index),
    .wdata (in_word.entry_rgb),
    .raddr (raddr),
    .rdata (rdata)
  );

  banp_dist u_dist (
    .clk     (clk),
    .rst_n   (rst_n),
    .rgb     (rdata),
    .avg     (avg_r),
    .tag_in  (s1_tag_r),
    .sq_dist (s2_dist),
    .tag_out (s2_tag)
  );

  assign raddr = (state_r == S_LOOKUP) ? pix_r[lk_cnt_r] : sr_cnt_r;

  // running best, updated by the distance stage
  always_comb begin
    best_idx_nxt  = best_idx_r;
    best_dist_nxt = best_dist_r;
    found_nxt     = found_r;
    if (s2_tag.v && (!found_r || s2_dist < best_dist_r)) begin
      best_idx_nxt  = s2_tag.idx;
      best_dist_nxt = s2_dist;
      found_nxt     = 1'b1;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    lk_cnt_nxt = lk_cnt_r;
    sr_cnt_nxt = sr_cnt_r;
    unique case (state_r)
      S_IDLE: begin
        lk_cnt_nxt = '0;
        sr_cnt_nxt = '0;
        if (in_acc && in_word.op == OP_BLOCK) begin
          state_nxt = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        lk_cnt_nxt = lk_cnt_r + 4'd1;
        if (lk_cnt_r == 4'(PIX_COUNT - 1)) begin
          state_nxt = S_LKEND;
        end
      end
      S_LKEND:  state_nxt = S_AVG;
      S_AVG:    state_nxt = S_SEARCH;
      S_SEARCH: begin
        sr_cnt_nxt = sr_cnt_r + 8'd1;
        if (sr_cnt_r == LAST_IDX) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (s2_tag.v && s2_tag.last) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      lk_cnt_r    <= '0;
      sr_cnt_r    <= '0;
      lk_v_r      <= 1'b0;
      s1_tag_r    <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      lk_cnt_r <= lk_cnt_nxt;
      sr_cnt_r <= sr_cnt_nxt;
      lk_v_r   <= (state_r == S_LOOKUP);
      s1_tag_r <= '{v: (state_r == S_SEARCH), idx: sr_cnt_r, last: (sr_cnt_r == LAST_IDX)};
      if (state_r == S_IDLE) begin
        found_r <= 1'b0;
      end else begin
        found_r <= found_nxt;
      end
      if (state_r == S_OUT && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_word.op == OP_BLOCK) begin
      pix_r[0] <= in_word.pix_00;
      pix_r[1] <= in_word.pix_01;
      pix_r[2] <= in_word.pix_02;
      pix_r[3] <= in_word.pix_10;
      pix_r[4] <= in_word.pix_11;
      pix_r[5] <= in_word.pix_12;
      pix_r[6] <= in_word.pix_20;
      pix_r[7] <= in_word.pix_21;
      pix_r[8] <= in_word.pix_22;
    end
    // channel sums of the looked-up colors
    if (state_r == S_IDLE) begin
      sum_r_r <= '0;
      sum_g_r <= '0;
      sum_b_r <= '0;
    end else if (lk_v_r) begin
      sum_r_r <= sum_r_r + 12'(rdata[23:16]);
      sum_g_r <= sum_g_r + 12'(rdata[15:8]);
      sum_b_r <= sum_b_r + 12'(rdata[7:0]);
    end
    if (state_r == S_AVG) begin
      avg_r <= {div9(sum_r_r), div9(sum_g_r), div9(sum_b_r)};
    end
    best_idx_r  <= best_idx_nxt;
    best_dist_r <= best_dist_nxt;
    if (state_r == S_OUT && (!out_valid_r || !out_stall)) begin
      out_word_r <= '{nearest_index: best_idx_r, best_distance: best_dist_r};
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // lookup reads and search reads never share the memory port
  a_port_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(lk_v_r && s1_tag_r.v))
    else $error("lookup and search reads overlap");

  // a block item always starts with the lookup phase
  a_block_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_word.op == OP_BLOCK) |=> (state_r == S_LOOKUP))
    else $error("block item did not start lookup");

  // by the time the result is loaded the search has seen at least one entry
  a_found: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT) |-> found_r)
    else $error("result without a searched entry");

  // distances stay within the range of three squared 8-bit differences
  a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
    s2_tag.v |-> (s2_dist <= 18'd195075))
    else $error("distance out of range");

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// testbench for box_average_nearest_palette: palette writes and 3x3 block words,
// each block's nearest searched color predicted and compared in arrival order
// depends on banp_pkg and the block's rtl
module tb;
  import banp_pkg::*;

  localparam int unsigned SEARCH_N     = 224;
  localparam int unsigned RANDOM_ITEMS = 276;
  localparam int unsigned LONG_HOLD    = 3000;
  localparam int unsigned QUIET_LIMIT  = 20000;

  class palette_scoreboard;
    rgb_t        shadow_pal[PAL_DEPTH];
    out_word_t   awaited_nearest[$];
    int unsigned search_n;
    int unsigned errors;

    function new(int unsigned n);
      search_n = n;
      errors   = 0;
      foreach (shadow_pal[i]) shadow_pal[i] = '0;
    endfunction

    function out_word_t nearest_of_block(in_word_t w);
      idx_t        pix[PIX_COUNT];
      int unsigned sum_r, sum_g, sum_b, cand_dist, best_dist, lim;
      int          avg_r, avg_g, avg_b, dr, dg, db;
      rgb_t        c;
      out_word_t   res;
      pix = '{w.pix_00, w.pix_01, w.pix_02, w.pix_10, w.pix_11, w.pix_12,
              w.pix_20, w.pix_21, w.pix_22};
      sum_r = 0;
      sum_g = 0;
      sum_b = 0;
      foreach (pix[k]) begin
        c = shadow_pal[pix[k]];
        sum_r += 32'(c[23:16]);
        sum_g += 32'(c[15:8]);
        sum_b += 32'(c[7:0]);
      end
      avg_r = sum_r / 9;
      avg_g = sum_g / 9;
      avg_b = sum_b / 9;
      lim = (search_n > PAL_DEPTH) ? PAL_DEPTH : search_n;
      res = '0;
      best_dist = 0;
      for (int unsigned k = 0; k < lim; k++) begin
        c  = shadow_pal[k];
        dr = int'(c[23:16]) - avg_r;
        dg = int'(c[15:8]) - avg_g;
        db = int'(c[7:0]) - avg_b;
        cand_dist = dr * dr + dg * dg + db * db;
        // strict compare, so the lowest index keeps a tie
        if (k == 0 || cand_dist < best_dist) begin
          best_dist = cand_dist;
          res.nearest_index = idx_t'(k);
        end
      end
      res.best_distance = dist_t'(best_dist);
      return res;
    endfunction

    function void note_input(in_word_t w);
      if (w.op == OP_WRITE) shadow_pal[w.entry_index] = w.entry_rgb;
      else awaited_nearest.push_back(nearest_of_block(w));
    endfunction

    function void check_result(out_word_t got);
      out_word_t want;
      if (awaited_nearest.size() == 0) begin
        $error("unexpected word: nearest_index %0d best_distance %0d",
               got.nearest_index, got.best_distance);
        errors++;
        return;
      end
      want = awaited_nearest.pop_front();
      if (got.nearest_index !== want.nearest_index) begin
        $error("nearest_index: expected %0d, got %0d", want.nearest_index, got.nearest_index);
        errors++;
      end
      if (got.best_distance !== want.best_distance) begin
        $error("best_distance: expected %0d, got %0d", want.best_distance, got.best_distance);
        errors++;
      end
    endfunction
  endclass

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_word_t  in_word   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;

  palette_scoreboard board;
  bit          hold_req     = 1'b0;
  bit          hold_done    = 1'b0;
  int unsigned burst_left   = 0;
  int unsigned quiet_cycles = 0;

  box_average_nearest_palette #(.SEARCH_ENTRIES(SEARCH_N)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic in_word_t noise_word();
    logic [127:0] r;
    r = {$urandom, $urandom, $urandom, $urandom};
    return r[$bits(in_word_t)-1:0];
  endfunction

  function automatic in_word_t write_word(idx_t idx, rgb_t rgb);
    in_word_t w;
    w = noise_word();
    w.op          = OP_WRITE;
    w.entry_index = idx;
    w.entry_rgb   = rgb;
    return w;
  endfunction

  function automatic in_word_t block_word(idx_t p[PIX_COUNT]);
    in_word_t w;
    w = noise_word();
    w.op     = OP_BLOCK;
    w.pix_00 = p[0];
    w.pix_01 = p[1];
    w.pix_02 = p[2];
    w.pix_10 = p[3];
    w.pix_11 = p[4];
    w.pix_12 = p[5];
    w.pix_20 = p[6];
    w.pix_21 = p[7];
    w.pix_22 = p[8];
    return w;
  endfunction

  // a few repeated colors so that ties come up often
  function automatic rgb_t pick_color();
    case ($urandom_range(0, 7))
      0: return 24'h000000;
      1: return 24'hFFFFFF;
      2: return 24'h808080;
      3: return 24'h102030;
      default: return rgb_t'($urandom);
    endcase
  endfunction

  task automatic send_word(input in_word_t w);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
    board.note_input(w);
  endtask

  initial begin
    idx_t pix[PIX_COUNT];
    idx_t one_idx;
    board = new(SEARCH_N);
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // searched entries black, the rest white
    for (int i = 0; i < PAL_DEPTH; i++)
      send_word(write_word(idx_t'(i), (i < SEARCH_N) ? 24'h000000 : 24'hFFFFFF));

    // white average against an all-black search range: largest distance
    pix = '{default: 8'd255};
    send_word(block_word(pix));
    pix = '{default: 8'd0};
    send_word(block_word(pix));
    // uneven sums exercise the floor of the divide
    pix = '{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd0};
    send_word(block_word(pix));
    pix = '{8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
    send_word(block_word(pix));
    // last searched entry, then an earlier twin that must win the tie
    send_word(write_word(8'd223, 24'hFFFFFF));
    pix = '{default: 8'd255};
    send_word(block_word(pix));
    send_word(write_word(8'd100, 24'hFFFFFF));
    send_word(block_word(pix));
    // mixed channels
    send_word(write_word(8'd224, 24'hFF0000));
    send_word(write_word(8'd225, 24'h00FF00));
    send_word(write_word(8'd226, 24'h0000FF));
    pix = '{8'd224, 8'd224, 8'd224, 8'd225, 8'd225, 8'd225, 8'd226, 8'd226, 8'd226};
    send_word(block_word(pix));
    send_word(write_word(8'd50, 24'h555555));
    send_word(block_word(pix));
    send_word(write_word(8'd10, 24'h123456));
    pix = '{default: 8'd10};
    send_word(block_word(pix));
    send_word(write_word(8'd0, 24'hFFFFFF));
    pix = '{default: 8'd255};
    send_word(block_word(pix));

    hold_req = 1'b1;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if ($urandom_range(0, 4) == 0) begin
        send_word(write_word(idx_t'($urandom), pick_color()));
      end else begin
        if ($urandom_range(0, 4) == 0) begin
          one_idx = idx_t'($urandom);
          foreach (pix[k]) pix[k] = one_idx;
        end else begin
          foreach (pix[k]) pix[k] = idx_t'($urandom);
        end
        send_word(block_word(pix));
      end
    end
    in_valid <= 1'b0;

    while (board.awaited_nearest.size() != 0) @(posedge clk);
    repeat (SEARCH_N + 40) @(posedge clk);
    if (board.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // receiver: one long hold-off early in the random part, otherwise segments
  // of free flow, light and heavy stalling
  initial begin
    int unsigned seg_len, mode;
    repeat (11) @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        mode    = $urandom_range(0, 3);
        seg_len = $urandom_range(20, 500);
        repeat (seg_len) begin
          case (mode)
            0: out_stall <= 1'b0;
            1: out_stall <= 1'($urandom_range(0, 1));
            2: out_stall <= ($urandom_range(0, 7) != 0);
            default: out_stall <= ($urandom_range(0, 9) == 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (out_valid && !out_stall) board.check_result(out_word);
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

endmodule

// ===== box_average_nearest_palette.f =====
design/banp_pkg.sv
design/banp_pal_mem.sv
design/banp_dist.sv
design/box_average_nearest_palette.sv
sim/tb.sv
